>>> design/lst_pkg.sv
// Shared constants, codes and control structs for the latency statistics table.
// No dependencies; every other design file except lst_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lst_pkg;

   localparam int unsigned NUM_SLOTS_DEFAULT = 16;
   localparam int unsigned SLOT_LIMIT        = 16;  // most results one snapshot emits
   localparam int unsigned TIME_W            = 64;
   localparam int unsigned SLOT_W            = 4;
   localparam int unsigned CSR_W             = 5;
   localparam int unsigned CNT_W             = 5;   // holds 0..SLOT_LIMIT

   localparam logic [CSR_W-1:0] CSR_RESET = CSR_W'(16);

   // action codes
   localparam logic ACT_RECORD   = 1'b0;
   localparam logic ACT_SNAPSHOT = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] count;
      logic [TIME_W-1:0] total;
      logic [TIME_W-1:0] min;
      logic [TIME_W-1:0] max;
   } lst_entry_type;

   localparam lst_entry_type ENTRY_CLEAR = '{
      count: '0,
      total: '0,
      min:   '1,
      max:   '0
   };

   // controller -> datapath
   typedef struct packed {
      logic              capture;   // latch elapsed time of a record beat
      logic              rd_en;     // read the table at rd_idx
      logic [CNT_W-1:0]  rd_idx;
      logic              update;    // write back the updated record entry
      logic              load_out;  // load the result register
      logic [SLOT_W-1:0] out_slot;
      logic              out_last;
      logic              clear_all; // drop every valid bit
   } lst_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
   } lst_stat_type;

endpackage

`default_nettype wire

>>> design/lst_req_if.sv
// Request channel interface: valid/ready handshake plus record/snapshot payload.
// Depends on lst_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lst_req_if import lst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [SLOT_W-1:0] slot;
   logic [TIME_W-1:0] start_time;
   logic [TIME_W-1:0] stop_time;

   modport source (output valid, action, slot, start_time, stop_time, input ready);
   modport sink   (input valid, action, slot, start_time, stop_time, output ready);
endinterface

`default_nettype wire

>>> design/lst_rsp_if.sv
// Response channel interface: valid/ready handshake plus one slot's statistics.
// Depends on lst_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lst_rsp_if import lst_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] slot_index;
   logic [TIME_W-1:0] call_count;
   logic [TIME_W-1:0] total_time;
   logic [TIME_W-1:0] min_time;
   logic [TIME_W-1:0] max_time;
   logic              last;

   modport source (output valid, slot_index, call_count, total_time, min_time, max_time,
                   last, input ready);
   modport sink   (input valid, slot_index, call_count, total_time, min_time, max_time,
                   last, output ready);
endinterface

`default_nettype wire

>>> design/lst_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lst_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic                                         rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/lst_ctrl.sv
// Controller: slot-count register, record/snapshot sequencing, request ready.
// Depends on lst_pkg; drives lst_cmd_type to the datapath.
`timescale 1ns / 1ps
`default_nettype none

module lst_ctrl import lst_pkg::*; #(
   parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_action,
   input  wire logic [SLOT_W-1:0] req_slot,
   output logic                   req_ready,
   input  wire logic              csr_wr_en,
   input  wire logic [CSR_W-1:0]  csr_wr_data,
   input  wire lst_stat_type      stat,
   output lst_cmd_type            cmd
);
   localparam int unsigned LIMIT_INT = (NUM_SLOTS < SLOT_LIMIT) ? NUM_SLOTS : SLOT_LIMIT;
   localparam logic [CNT_W-1:0] LIMIT = CNT_W'(LIMIT_INT);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DUMP
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CSR_W-1:0] slots_ff;
   logic [CNT_W-1:0] active;
   logic [CNT_W-1:0] idx_next;
   logic             is_last;

   // clamp to 1..LIMIT
   always_comb begin
      if (slots_ff == '0) begin
         active = CNT_W'(1);
      end else if (CNT_W'(slots_ff) > LIMIT) begin
         active = LIMIT;
      end else begin
         active = CNT_W'(slots_ff);
      end
   end

   assign idx_next = idx_ff + CNT_W'(1);
   assign is_last  = (idx_next == active);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_SNAPSHOT) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_idx = '0;
                  idx_in     = '0;
                  state_in   = ST_DUMP;
               end else if (CNT_W'(req_slot) < active) begin
                  cmd.capture = 1'b1;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_idx  = CNT_W'(req_slot);
                  state_in    = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_DUMP: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_slot = idx_ff[SLOT_W-1:0];
               cmd.out_last = is_last;
               if (is_last) begin
                  cmd.clear_all = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_idx = idx_next;
                  idx_in     = idx_next;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         slots_ff <= CSR_RESET;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr_wr_en) begin
            slots_ff <= csr_wr_data;
         end
      end
   end

endmodule

`default_nettype wire

>>> design/lst_dp.sv
// Datapath: statistics RAM with per-slot valid bits, elapsed-time and update
// arithmetic, result register. Depends on lst_pkg, lst_ram, lst_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module lst_dp import lst_pkg::*; #(
   parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lst_cmd_type       cmd,
   output lst_stat_type           stat,
   input  wire logic [TIME_W-1:0] start_time,
   input  wire logic [TIME_W-1:0] stop_time,
   lst_rsp_if.source              rsp_chan
);
   localparam int unsigned ADDR_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int unsigned EXT_W   = ADDR_W + CNT_W;
   localparam int unsigned ENTRY_W = $bits(lst_entry_type);

   logic [EXT_W-1:0]     idx_ext;
   logic [ADDR_W-1:0]    rd_addr, rd_addr_ff;
   logic [NUM_SLOTS-1:0] valid_ff;
   logic                 rd_valid_ff;
   logic [TIME_W-1:0]    elapsed_ff, elapsed_in;
   logic [ENTRY_W-1:0]   ram_rd_data;
   lst_entry_type        entry_cur, entry_new;
   lst_entry_type        out_ff;
   logic [SLOT_W-1:0]    out_slot_ff;
   logic                 out_last_ff;
   logic                 rsp_valid_ff;

   assign idx_ext = EXT_W'(cmd.rd_idx);
   assign rd_addr = idx_ext[ADDR_W-1:0];

   assign elapsed_in = (stop_time > start_time) ? (stop_time - start_time) : '0;

   // entry never written since the last clear reads as the cleared value
   assign entry_cur = rd_valid_ff ? lst_entry_type'(ram_rd_data) : ENTRY_CLEAR;

   always_comb begin
      entry_new.count = entry_cur.count + TIME_W'(1);
      entry_new.total = entry_cur.total + elapsed_ff;
      entry_new.min   = (entry_cur.min > elapsed_ff) ? elapsed_ff : entry_cur.min;
      entry_new.max   = (entry_cur.max < elapsed_ff) ? elapsed_ff : entry_cur.max;
   end

   lst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (rd_addr_ff),
      .wr_data (ENTRY_W'(entry_new)),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         elapsed_ff <= elapsed_in;
      end
      if (cmd.rd_en) begin
         rd_addr_ff <= rd_addr;
      end
      if (cmd.load_out) begin
         out_ff      <= entry_cur;
         out_slot_ff <= cmd.out_slot;
         out_last_ff <= cmd.out_last;
      end
      if (reset) begin
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
         if (cmd.clear_all) begin
            valid_ff <= '0;
         end else if (cmd.update) begin
            valid_ff[rd_addr_ff] <= 1'b1;
         end
         rsp_valid_ff <= cmd.load_out | (rsp_valid_ff & ~rsp_chan.ready);
      end
   end

   assign stat.out_free = ~rsp_valid_ff | rsp_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.slot_index = out_slot_ff;
   assign rsp_chan.call_count = out_ff.count;
   assign rsp_chan.total_time = out_ff.total;
   assign rsp_chan.min_time   = out_ff.min;
   assign rsp_chan.max_time   = out_ff.max;
   assign rsp_chan.last       = out_last_ff;

endmodule

`default_nettype wire

>>> design/latency_stats_table.sv
// Latency statistics table: per-slot count, total, min and max of elapsed times.
// Top level; depends on lst_pkg, lst_req_if, lst_rsp_if, lst_ctrl, lst_dp, lst_ram.
//
// Usage
//   req_chan (sink): one beat is either a record (action = record) naming a slot with
//     start/stop timestamps, or a snapshot (action = snapshot). Record beats produce
//     no response; records to a slot at or above the active count are dropped.
//   rsp_chan (source): a snapshot emits one beat per active slot, slot 0 first,
//     with last set on the final beat; the table is then cleared.
//   csr_wr_en / csr_wr_data: active slot count, 0 acts as 1, values above
//     min(NUM_SLOTS, 16) are clamped. Write only while the block is idle.
// Timing
//   Record: read-modify-write on the single-read-port stats RAM; req_chan.ready is low
//     during the write-back, so the next beat waits; a dropped record leaves ready high.
//   Snapshot: slots pass through the RAM read register into the response register, one
//     beat per cycle while rsp_chan.ready is high; req_chan.ready returns the cycle after
//     the last beat is loaded into the response register, even if that beat is still held.
//   Receiver stall: the response register holds its beat and the slot walk pauses.
// Reset: synchronous; all slots read as cleared (per-slot valid bits drop at
//   once, no clearing pass), the active count returns to min(NUM_SLOTS, 16).

`timescale 1ns / 1ps
`default_nettype none

module latency_stats_table import lst_pkg::*; #(
   parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   lst_req_if.sink               req_chan,
   lst_rsp_if.source             rsp_chan,
   input  wire logic             csr_wr_en,
   input  wire logic [CSR_W-1:0] csr_wr_data
);

   lst_cmd_type  cmd;
   lst_stat_type stat;
   logic         req_ready;

   // sequencing: record update vs. snapshot walk
   lst_ctrl #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_action  (req_chan.action),
      .req_slot    (req_chan.slot),
      .req_ready   (req_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stat        (stat),
      .cmd         (cmd)
   );

   // table storage, arithmetic and the response register
   lst_dp #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .start_time (req_chan.start_time),
      .stop_time  (req_chan.stop_time),
      .rsp_chan   (rsp_chan)
   );

   assign req_chan.ready = req_ready;

   // a snapshot beat locks out new requests while the slots are walked
   a_snap_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.action == ACT_SNAPSHOT)
      |=> !req_chan.ready)
      else $error("request accepted right after a snapshot beat");

   // write-back only follows a captured record
   a_update_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $past(cmd.capture))
      else $error("table write without a captured record");

   // table cleared only together with the final snapshot beat
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_all |-> (cmd.load_out && cmd.out_last))
      else $error("table cleared outside the final snapshot beat");

   // response valid rises only after a result load
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.load_out))
      else $error("response valid without a loaded result");

endmodule

`default_nettype wire
